@@ rtl/satlb_pkg.sv @@
// satlb_pkg: shared types, command codes and tag masking for the TLB
// no dependencies; used by satlb_probe, set_assoc_tlb_lookup_fill and tb
`default_nettype none

package satlb_pkg;

  localparam int ADDR_W = 32;
  localparam int DATA_W = 32;
  localparam int KIND_W = 2;
  localparam int TAG_W  = 22;
  localparam int WAYO_W = 2;

  // command codes
  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_FILL   = 2'd1,
    CMD_FLUSH  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  // page kinds
  typedef enum logic [1:0] {
    KIND_SECTION = 2'd0,
    KIND_LARGE   = 2'd1,
    KIND_SMALL   = 2'd2,
    KIND_TINY    = 2'd3
  } kind_e;

  // control sequencer states
  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_SET   = 2'd2,
    ST_PROC  = 2'd3
  } fsm_e;

  // one way of a set row
  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] data;
  } entry_t;

  // result of one item
  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] data;
    logic [KIND_W-1:0] kind;
    logic [WAYO_W-1:0] way;
  } result_t;

  // tag is vaddr[31:10] with the bits below the page size cleared
  function automatic logic [TAG_W-1:0] masked_tag(input logic [ADDR_W-1:0] addr,
                                                 input kind_e kind);
    logic [TAG_W-1:0] t;
    t = addr[ADDR_W-1:ADDR_W-TAG_W];
    case (kind)
      KIND_SECTION: masked_tag = {t[21:10], 10'd0};
      KIND_LARGE:   masked_tag = {t[21:6], 6'd0};
      KIND_SMALL:   masked_tag = {t[21:2], 2'd0};
      KIND_TINY:    masked_tag = t;
      default:      masked_tag = t;
    endcase
  endfunction

endpackage

`default_nettype wire

@@ rtl/set_assoc_tlb_lookup_fill.sv @@
// set_assoc_tlb_lookup_fill: set-associative TLB, lookup / fill / flush
// depends on satlb_pkg and satlb_probe
//
//   channel | direction | handshake              | fields
//   --------+-----------+------------------------+-------------------------------------
//   in      | to block  | in_valid_i, in_stall_o | cmd_i vaddr_i page_kind_i entry_data_i
//   out     | from block| out_valid_o,out_stall_i| hit_o data_out_o kind_out_o way_out_o
//
// An item goes through accept (set quotient by reciprocal multiply), set index
// and row read from the set memories, then resolve and write back.
// After reset and after each flush a clearing pass zeroes valid bits and way
// pointers, one set per cycle, and no item is accepted until every set is cleared.
// The resolve step waits while a previous result is still stalled at the output.
`default_nettype none

module set_assoc_tlb_lookup_fill #(
  parameter int SETS = 16,
  parameter int WAYS = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [1:0]                       cmd_i,
  input  wire logic [satlb_pkg::ADDR_W-1:0]     vaddr_i,
  input  wire logic [satlb_pkg::KIND_W-1:0]     page_kind_i,
  input  wire logic [satlb_pkg::DATA_W-1:0]     entry_data_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic                                  hit_o,
  output logic [satlb_pkg::DATA_W-1:0]          data_out_o,
  output logic [satlb_pkg::KIND_W-1:0]          kind_out_o,
  output logic [satlb_pkg::WAYO_W-1:0]          way_out_o
);

  localparam int SW      = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int META_W  = WW + WAYS;
  localparam int RSH     = 25;
  localparam int unsigned RECIP = ((32'd1 << RSH) + SETS - 1) / SETS;

  // sequencer and item registers
  satlb_pkg::fsm_e state_q, state_d;
  logic [SW-1:0]   clr_q, clr_d;
  satlb_pkg::cmd_e cmd_q;
  logic [satlb_pkg::ADDR_W-1:0] vaddr_q;
  logic [satlb_pkg::KIND_W-1:0] kind_q;
  logic [satlb_pkg::DATA_W-1:0] data_q;
  logic [11:0]     quo_q;
  logic [SW-1:0]   set_q;

  // set memories: meta row {pointer, valid bits} and entry row
  logic [META_W-1:0]              meta_mem [SETS];
  satlb_pkg::entry_t [WAYS-1:0]   ent_mem  [SETS];
  logic [META_W-1:0]              meta_rd_q;
  satlb_pkg::entry_t [WAYS-1:0]   ent_rd_q;

  logic                           rd_en;
  logic                           meta_we;
  logic [SW-1:0]                  meta_waddr;
  logic [META_W-1:0]              meta_wdata;
  logic                           ent_we;
  satlb_pkg::entry_t [WAYS-1:0]   ent_wdata;

  // output register
  logic              out_valid_q, out_valid_d;
  satlb_pkg::result_t res_q;
  satlb_pkg::result_t probe_res;
  logic [WW-1:0]     fill_way;
  logic              out_free;
  logic              in_acc;
  logic              res_load;

  // quotient of vaddr[31:20] / SETS by reciprocal multiply
  logic [37:0]       quo_prod;
  logic [23:0]       set_prod;
  logic [11:0]       set_rem;
  logic [SW-1:0]     set_idx;

  assign quo_prod = 38'(vaddr_i[31:20]) * 38'(RECIP);
  assign set_prod = 24'(quo_q) * 24'(SETS);
  assign set_rem  = 12'(24'(vaddr_q[31:20]) - set_prod);
  assign set_idx  = SW'(set_rem);

  assign in_stall_o = (state_q != satlb_pkg::ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  satlb_probe #(
    .WAYS (WAYS)
  ) u_probe (
    .cmd_i      (cmd_q),
    .vaddr_i    (vaddr_q),
    .ptr_i      (meta_rd_q[META_W-1:WAYS]),
    .valid_i    (meta_rd_q[WAYS-1:0]),
    .row_i      (ent_rd_q),
    .res_o      (probe_res),
    .fill_way_o (fill_way)
  );

  // next state and memory controls
  always_comb begin
    logic [WAYS-1:0] vld_new;
    state_d    = state_q;
    clr_d      = clr_q;
    rd_en      = 1'b0;
    meta_we    = 1'b0;
    meta_waddr = set_q;
    meta_wdata = '0;
    ent_we     = 1'b0;
    ent_wdata  = ent_rd_q;
    res_load   = 1'b0;
    vld_new    = meta_rd_q[WAYS-1:0];
    vld_new[fill_way] = 1'b1;
    ent_wdata[fill_way].tag  =
      satlb_pkg::masked_tag(vaddr_q, satlb_pkg::kind_e'(kind_q));
    ent_wdata[fill_way].kind = kind_q;
    ent_wdata[fill_way].data = data_q;
    case (state_q)
      satlb_pkg::ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_q;
        meta_wdata = '0;
        clr_d      = clr_q + SW'(1);
        if (clr_q == SW'(SETS - 1)) begin
          clr_d   = '0;
          state_d = satlb_pkg::ST_IDLE;
        end
      end
      satlb_pkg::ST_IDLE: begin
        if (in_acc) state_d = satlb_pkg::ST_SET;
      end
      satlb_pkg::ST_SET: begin
        rd_en   = 1'b1;
        state_d = satlb_pkg::ST_PROC;
      end
      satlb_pkg::ST_PROC: begin
        if (out_free) begin
          res_load = 1'b1;
          state_d  = satlb_pkg::ST_IDLE;
          if (cmd_q == satlb_pkg::CMD_FILL) begin
            meta_we    = 1'b1;
            meta_wdata = {fill_way, vld_new};
            ent_we     = 1'b1;
          end
          if (cmd_q == satlb_pkg::CMD_FLUSH) begin
            clr_d   = '0;
            state_d = satlb_pkg::ST_CLEAR;
          end
        end
      end
      default: begin
        state_d = satlb_pkg::ST_CLEAR;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= satlb_pkg::ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_d = res_load ? 1'b1 : (out_valid_q && out_stall_i);

  // item and datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q   <= satlb_pkg::cmd_e'(cmd_i);
      vaddr_q <= vaddr_i;
      kind_q  <= page_kind_i;
      data_q  <= entry_data_i;
      quo_q   <= quo_prod[RSH+11:RSH];
    end
    if (state_q == satlb_pkg::ST_SET) begin
      set_q <= set_idx;
    end
    if (res_load) begin
      res_q <= probe_res;
    end
  end

  // set memories, registered read
  always_ff @(posedge clk_i) begin
    if (meta_we) begin
      meta_mem[meta_waddr] <= meta_wdata;
    end
    if (ent_we) begin
      ent_mem[set_q] <= ent_wdata;
    end
    if (rd_en) begin
      meta_rd_q <= meta_mem[set_idx];
      ent_rd_q  <= ent_mem[set_idx];
    end
  end

  assign out_valid_o = out_valid_q;
  assign hit_o       = res_q.hit;
  assign data_out_o  = res_q.data;
  assign kind_out_o  = res_q.kind;
  assign way_out_o   = res_q.way;

endmodule

`default_nettype wire

@@ rtl/satlb_probe.sv @@
// satlb_probe: compares one set row against an address and picks the hit way
// and the fill victim way; depends on satlb_pkg
`default_nettype none

module satlb_probe #(
  parameter int WAYS = 4,
  localparam int WW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  wire satlb_pkg::cmd_e                  cmd_i,
  input  wire logic [satlb_pkg::ADDR_W-1:0]     vaddr_i,
  input  wire logic [WW-1:0]                    ptr_i,
  input  wire logic [WAYS-1:0]                  valid_i,
  input  wire satlb_pkg::entry_t [WAYS-1:0]     row_i,
  output satlb_pkg::result_t                    res_o,
  output logic [WW-1:0]                         fill_way_o
);

  logic [WAYS-1:0] match;
  logic [WW-1:0]   hit_way;
  logic            any_hit;

  // per-way tag compare, each entry masked by its own kind
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      match[w] = valid_i[w] &&
                 (row_i[w].tag ==
                  satlb_pkg::masked_tag(vaddr_i, satlb_pkg::kind_e'(row_i[w].kind)));
    end
  end

  // probe downward from the pointer; the nearest match wins
  always_comb begin
    int          wi;
    logic [WW-1:0] idx;
    hit_way = '0;
    any_hit = 1'b0;
    for (int k = WAYS - 1; k >= 0; k--) begin
      if (int'(ptr_i) >= k) wi = int'(ptr_i) - k;
      else                  wi = int'(ptr_i) + WAYS - k;
      idx = WW'(wi);
      if (match[idx]) begin
        hit_way = idx;
        any_hit = 1'b1;
      end
    end
  end

  // first invalid way above the pointer, else round robin
  always_comb begin
    int          wi;
    logic [WW-1:0] idx;
    wi = int'(ptr_i) + 1;
    if (wi >= WAYS) wi = wi - WAYS;
    fill_way_o = WW'(wi);
    for (int k = WAYS; k >= 1; k--) begin
      wi = int'(ptr_i) + k;
      if (wi >= WAYS) wi = wi - WAYS;
      idx = WW'(wi);
      if (!valid_i[idx]) fill_way_o = idx;
    end
  end

  // result fields per command
  always_comb begin
    res_o = '0;
    case (cmd_i)
      satlb_pkg::CMD_LOOKUP: begin
        if (any_hit) begin
          res_o.hit  = 1'b1;
          res_o.data = row_i[hit_way].data;
          res_o.kind = row_i[hit_way].kind;
          res_o.way  = satlb_pkg::WAYO_W'(hit_way);
        end
      end
      satlb_pkg::CMD_FILL: begin
        res_o.way = satlb_pkg::WAYO_W'(fill_way_o);
      end
      default: begin
        res_o = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for set_assoc_tlb_lookup_fill
// depends on satlb_pkg (command and kind codes, result type) and the block itself
`default_nettype none

// expected-result tracker: keeps its own copy of the tlb contents and predicts
// the result of every accepted item
class tlb_scoreboard;
  localparam int SETS = 16;
  localparam int WAYS = 4;

  logic [21:0]      tags    [SETS][WAYS];
  satlb_pkg::kind_e kinds   [SETS][WAYS];
  bit               valids  [SETS][WAYS];
  logic [31:0]      payloads[SETS][WAYS];
  int               rr_ptr  [SETS];

  satlb_pkg::result_t expected_results[$];
  int errors;

  function new();
    for (int s = 0; s < SETS; s++) begin
      rr_ptr[s] = 0;
      for (int w = 0; w < WAYS; w++) begin
        tags[s][w]     = '0;
        kinds[s][w]    = satlb_pkg::KIND_SECTION;
        valids[s][w]   = 1'b0;
        payloads[s][w] = '0;
      end
    end
    errors = 0;
  endfunction

  // tag of an address as seen through the page size of the given kind
  function logic [21:0] page_tag(logic [31:0] addr, satlb_pkg::kind_e kind);
    logic [31:0] m;
    case (kind)
      satlb_pkg::KIND_SECTION: m = 32'hFFF0_0000;
      satlb_pkg::KIND_LARGE:   m = 32'hFFFF_0000;
      satlb_pkg::KIND_SMALL:   m = 32'hFFFF_F000;
      default:                 m = 32'hFFFF_FC00;
    endcase
    return 22'((addr & m) >> 10);
  endfunction

  // update the tlb copy and queue the result of one accepted item
  function void note_item(satlb_pkg::cmd_e cmd, logic [31:0] vaddr,
                          satlb_pkg::kind_e kind, logic [31:0] data);
    satlb_pkg::result_t res;
    int set;
    int w;
    bit found;
    res = '0;
    set = int'(vaddr[23:20]);
    w = rr_ptr[set];
    found = 1'b0;
    case (cmd)
      satlb_pkg::CMD_LOOKUP: begin
        // probe downward from the pointer, first match wins
        for (int i = 0; i < WAYS; i++) begin
          if (!found && valids[set][w] && tags[set][w] == page_tag(vaddr, kinds[set][w])) begin
            found = 1'b1;
            res.hit = 1'b1;
            res.data = payloads[set][w];
            res.kind = kinds[set][w];
            res.way = w[1:0];
          end
          if (!found) w = (w + WAYS - 1) % WAYS;
        end
      end
      satlb_pkg::CMD_FILL: begin
        // first invalid way above the pointer, else round robin
        for (int i = 0; i < WAYS; i++) begin
          if (!found) begin
            w = (w + 1) % WAYS;
            if (!valids[set][w]) found = 1'b1;
          end
        end
        if (!found) w = (rr_ptr[set] + 1) % WAYS;
        rr_ptr[set] = w;
        tags[set][w] = page_tag(vaddr, kind);
        kinds[set][w] = kind;
        payloads[set][w] = data;
        valids[set][w] = 1'b1;
        res.way = w[1:0];
      end
      satlb_pkg::CMD_FLUSH: begin
        for (int s = 0; s < SETS; s++) begin
          rr_ptr[s] = 0;
          for (int j = 0; j < WAYS; j++) valids[s][j] = 1'b0;
        end
      end
      default: ;
    endcase
    expected_results.push_back(res);
  endfunction

  function void report_field(string field, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
    end
  endfunction

  // compare one accepted result with the oldest expectation
  function void check_result(logic hit, logic [31:0] data, logic [1:0] kind, logic [1:0] way);
    satlb_pkg::result_t exp_r;
    if (expected_results.size() == 0) begin
      errors++;
      $display("%0t: unexpected result, expected none actual hit=%b data=%h kind=%h way=%h",
               $time, hit, data, kind, way);
      return;
    end
    exp_r = expected_results.pop_front();
    report_field("hit", 32'(exp_r.hit), 32'(hit));
    report_field("data_out", exp_r.data, data);
    report_field("kind_out", 32'(exp_r.kind), 32'(kind));
    report_field("way_out", 32'(exp_r.way), 32'(way));
  endfunction

  function int pending();
    return expected_results.size();
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  satlb_pkg::cmd_e cmd = satlb_pkg::CMD_NOP;
  logic [31:0] vaddr = '0;
  satlb_pkg::kind_e page_kind = satlb_pkg::KIND_SECTION;
  logic [31:0] entry_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic hit;
  logic [31:0] data_out;
  logic [1:0] kind_out;
  logic [1:0] way_out;

  bit quiet = 1'b0;
  bit hold_req = 1'b0;
  int unsigned cycles = 0;
  logic [31:0] addr_pool[12];
  tlb_scoreboard sb;

  set_assoc_tlb_lookup_fill dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .cmd_i        (cmd),
    .vaddr_i      (vaddr),
    .page_kind_i  (page_kind),
    .entry_data_i (entry_data),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .hit_o        (hit),
    .data_out_o   (data_out),
    .kind_out_o   (kind_out),
    .way_out_o    (way_out)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("** set_assoc_tlb_lookup_fill: FAILED **");
      $finish;
    end
  end

  // monitor both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (in_valid && !in_stall) sb.note_item(cmd, vaddr, page_kind, entry_data);
      if (out_valid && !out_stall) sb.check_result(hit, data_out, kind_out, way_out);
    end
  end

  // receiver: random stall bursts, one long hold-off on request, none when quiet
  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        if (!quiet) repeat ($urandom_range(0, 12)) @(negedge clk);
      end
    end
  end

  // offer one item after an optional idle burst, return once it is accepted
  task automatic send_item(satlb_pkg::cmd_e c, logic [31:0] a, satlb_pkg::kind_e k,
                           logic [31:0] d);
    int gap;
    gap = 0;
    if (!quiet && !hold_req && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 16);
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    cmd <= c;
    vaddr <= a;
    page_kind <= k;
    entry_data <= d;
    do @(posedge clk); while (in_stall);
  endtask

  // address close to a pool entry: same page, same section, or nearby
  function automatic logic [31:0] pool_addr();
    logic [31:0] a;
    a = addr_pool[$urandom_range(0, 11)];
    case ($urandom_range(0, 3))
      0: a = a ^ $urandom_range(0, 32'h3FF);
      1: a = a ^ $urandom_range(0, 32'hFFFF);
      2: a = a ^ $urandom_range(0, 32'hFFFFF);
      default: ;
    endcase
    return a;
  endfunction

  // mostly lookups and fills around the address pool, some noise
  task automatic random_item();
    int pick;
    satlb_pkg::kind_e k;
    pick = $urandom_range(0, 99);
    k = satlb_pkg::kind_e'($urandom_range(0, 3));
    if (pick < 4) addr_pool[$urandom_range(0, 11)] = {$urandom} & 32'hFC3F_FFFF;
    if (pick < 45)
      send_item(satlb_pkg::CMD_LOOKUP, pool_addr(), k, $urandom);
    else if (pick < 85)
      send_item(satlb_pkg::CMD_FILL, pool_addr(), k, $urandom);
    else if (pick < 87)
      send_item(satlb_pkg::CMD_FLUSH, $urandom, k, $urandom);
    else if (pick < 91)
      send_item(satlb_pkg::CMD_NOP, $urandom, k, $urandom);
    else
      send_item(satlb_pkg::CMD_LOOKUP, $urandom, k, $urandom);
  endtask

  initial begin
    sb = new();
    // pool addresses crowd into sets 0..3 so replacement gets exercised
    foreach (addr_pool[i]) addr_pool[i] = {$urandom} & 32'hFC3F_FFFF;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty lookup, each kind, set overflow, duplicates, nop, flush
    send_item(satlb_pkg::CMD_LOOKUP, 32'h0000_0000, satlb_pkg::KIND_SECTION, 32'h0);
    send_item(satlb_pkg::CMD_FILL, 32'hFFF0_0000, satlb_pkg::KIND_SECTION, 32'hFFFF_FFFF);
    send_item(satlb_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, satlb_pkg::KIND_SECTION, 32'h0);
    send_item(satlb_pkg::CMD_FILL, 32'h0001_0000, satlb_pkg::KIND_LARGE, 32'h0);
    send_item(satlb_pkg::CMD_FILL, 32'h0000_F000, satlb_pkg::KIND_SMALL, 32'hA5A5_A5A5);
    send_item(satlb_pkg::CMD_FILL, 32'h0000_FC00, satlb_pkg::KIND_TINY, 32'h5A5A_5A5A);
    send_item(satlb_pkg::CMD_FILL, 32'h000F_FC00, satlb_pkg::KIND_TINY, 32'h1234_5678);
    send_item(satlb_pkg::CMD_FILL, 32'h0000_0000, satlb_pkg::KIND_SECTION, 32'h8765_4321);
    send_item(satlb_pkg::CMD_LOOKUP, 32'h0000_FC00, satlb_pkg::KIND_SECTION, 32'h0);
    send_item(satlb_pkg::CMD_LOOKUP, 32'h0001_FFFF, satlb_pkg::KIND_SECTION, 32'h0);
    send_item(satlb_pkg::CMD_LOOKUP, 32'h000F_FFFF, satlb_pkg::KIND_SECTION, 32'h0);
    send_item(satlb_pkg::CMD_FILL, 32'h0000_F000, satlb_pkg::KIND_SMALL, 32'hDEAD_BEEF);
    send_item(satlb_pkg::CMD_LOOKUP, 32'h0000_F123, satlb_pkg::KIND_SECTION, 32'h0);
    send_item(satlb_pkg::CMD_NOP, 32'hFFFF_FFFF, satlb_pkg::KIND_TINY, 32'hFFFF_FFFF);
    send_item(satlb_pkg::CMD_LOOKUP, 32'h0000_0000, satlb_pkg::KIND_TINY, 32'hFFFF_FFFF);
    send_item(satlb_pkg::CMD_FLUSH, 32'h0000_0000, satlb_pkg::KIND_SECTION, 32'h0);
    send_item(satlb_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, satlb_pkg::KIND_SECTION, 32'h0);
    send_item(satlb_pkg::CMD_FILL, 32'hFFFF_FFFF, satlb_pkg::KIND_TINY, 32'h0);
    send_item(satlb_pkg::CMD_LOOKUP, 32'hFFFF_FC00, satlb_pkg::KIND_SECTION, 32'h0);
    send_item(satlb_pkg::CMD_LOOKUP, 32'hFFFF_FBFF, satlb_pkg::KIND_SECTION, 32'h0);

    // receiver holds off while items keep coming, the block backs up
    hold_req = 1'b1;
    repeat (40) random_item();

    // random traffic with idling on both sides
    repeat (680) random_item();

    // final stretch at full rate
    quiet = 1'b1;
    repeat (120) random_item();
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then keep watching for anything stray
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** set_assoc_tlb_lookup_fill: PASSED **");
    end else begin
      $display("** set_assoc_tlb_lookup_fill: FAILED **");
    end
    $finish;
  end
endmodule

`default_nettype wire

@@ sim.f @@
rtl/satlb_pkg.sv
rtl/satlb_probe.sv
rtl/set_assoc_tlb_lookup_fill.sv
tb/sv/tb.sv
